// ===== design/lsct_pkg.sv =====
// Package for the load switch cycle tester: payload structs, status and
// register index codes, reset values of the settings registers.
// No dependencies.
package lsct_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_W           = 16;
    localparam int LIMIT_W         = 4;

    localparam logic [CFG_W-1:0]   LOAD_TICKS_RST   = 16'd10;
    localparam logic [CFG_W-1:0]   UNLOAD_TICKS_RST = 16'd10;
    localparam logic [CFG_W-1:0]   TOTAL_TESTS_RST  = 16'd1000;
    localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST   = 4'd3;
    localparam logic [LIMIT_W-1:0] FAIL_RUN_MAX     = 4'd15;

    typedef enum logic [1:0] {
        CFG_LOAD_TICKS   = 2'd0,
        CFG_UNLOAD_TICKS = 2'd1,
        CFG_TOTAL_TESTS  = 2'd2,
        CFG_FAIL_LIMIT   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_RUNNING    = 3'd0,
        ST_PASSED     = 3'd1,
        ST_RELAY_ERR  = 3'd2,
        ST_CHIP_ERR   = 3'd3,
        ST_SUPPLY_ERR = 3'd4,
        ST_QUIT       = 3'd5
    } t_status;

    typedef struct packed {
        logic [CFG_W-1:0]   load_ticks;
        logic [CFG_W-1:0]   unload_ticks;
        logic [CFG_W-1:0]   total_tests;
        logic [LIMIT_W-1:0] relay_fail_limit;
    } t_cfg;

    typedef struct packed {
        logic tick_elapsed;
        logic relay_sense;
        logic supply_sense;
        logic vout_sense;
        logic quit_pressed;
    } t_in;

    typedef struct packed {
        logic        relay_load;
        logic        chip_enable;
        logic [15:0] shown_test_number;
        logic        show_number;
        logic [2:0]  run_status;
    } t_result;

endpackage

// ===== design/lsct_in_if.sv =====
// Request channel carrying one sample of the sensed pins.
// Depends on lsct_pkg.
interface lsct_in_if import lsct_pkg::*; ;
    logic valid;
    logic ready;
    t_in  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/lsct_out_if.sv =====
// Result channel carrying the drive levels and run status of one step.
// Depends on lsct_pkg.
interface lsct_out_if import lsct_pkg::*; ;
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/load_switch_cycle_tester_top.sv =====
// Load switch cycle tester: top level with input and result registers.
// Depends on lsct_pkg, lsct_in_if, lsct_out_if, lsct_cfg and lsct_core.
//
// Usage:
//   i_in carries one request per sample of the sensed pins; tick_elapsed
//   marks a 100 ms period and advances the load/unload sequence.
//   o_out carries exactly one result per request: relay and chip enable
//   drive, the shown test number, a show strobe and the run status.
//   The settings port (i_cfg_we, i_cfg_idx, i_cfg_data) writes load_ticks,
//   unload_ticks, total_tests and relay_fail_limit; write only while idle.
// Flow: a request is captured in the input register, then stepped through the
//   sequencer into the result register, which presents it on o_out.
// Throughput: one request per cycle while o_out is taken; the sequencer state
//   update is a single counter step and compare chain, so it keeps up every cycle.
// Reset (synchronous, active low): settings return to their defaults,
//   test number 1, relay unloaded, chip enabled, status running.
// Stall: when o_out is not taken the result holds and the input register
//   takes one more request; i_in.ready then drops until o_out drains.
// Once the status is not running, every request repeats the final outputs.
module load_switch_cycle_tester_top import lsct_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    lsct_in_if.sink          i_in,
    lsct_out_if.source       o_out
);

    t_cfg    cfg;
    t_result core_result;

    logic    r_in_valid;
    t_in     r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;

    // step the sequencer when the held request can move into the result register
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    lsct_cfg #(.COUNT_WIDTH(COUNT_WIDTH)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lsct_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_in     (r_in),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // input register: capture a new request, or drop the held one once stepped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // result register: load on a step, drain when the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef NO_ASSERTIONS
    // a chip error always leaves the chip disabled
    a_chip_err_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.run_status == ST_CHIP_ERR |-> !r_out.chip_enable)
        else $error("chip error reported with chip enabled");

    // a held request that cannot step stays in the input register unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("held request lost while stalled");

    // once the run has ended, later results repeat the final status
    a_status_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.run_status != ST_RUNNING && advance
        |=> r_out.run_status == $past(r_out.run_status))
        else $error("final status changed after the run ended");
`endif

endmodule

// ===== design/lsct_cfg.sv =====
// Settings registers of the cycle tester; tick and test settings are masked to the counter width.
// Depends on lsct_pkg.
module lsct_cfg import lsct_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    localparam logic [CFG_W-1:0] CFG_MASK =
        CFG_W'((33'd1 << COUNT_WIDTH) - 33'd1);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.load_ticks       <= LOAD_TICKS_RST & CFG_MASK;
            r_cfg.unload_ticks     <= UNLOAD_TICKS_RST & CFG_MASK;
            r_cfg.total_tests      <= TOTAL_TESTS_RST & CFG_MASK;
            r_cfg.relay_fail_limit <= FAIL_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LOAD_TICKS:   r_cfg.load_ticks   <= i_cfg_data & CFG_MASK;
                CFG_UNLOAD_TICKS: r_cfg.unload_ticks <= i_cfg_data & CFG_MASK;
                CFG_TOTAL_TESTS:  r_cfg.total_tests  <= i_cfg_data & CFG_MASK;
                CFG_FAIL_LIMIT:   r_cfg.relay_fail_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/lsct_core.sv =====
// Sequencer state and its single-step update: tick counters, end-of-cycle
// checks and final status. Depends on lsct_pkg.
module lsct_core import lsct_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_in     i_in,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int CW = COUNT_WIDTH;
    localparam int WW = COUNT_WIDTH + 1;

    logic [CW-1:0]      r_load_left,   n_load_left;
    logic [WW-1:0]      r_unload_left, n_unload_left;
    logic               r_cycle_done,  n_cycle_done;
    logic [LIMIT_W-1:0] r_fail_run,    n_fail_run;
    logic [WW-1:0]      r_test_index,  n_test_index;
    logic               r_pending,     n_pending;
    logic               r_quit,        n_quit;
    logic               r_relay,       n_relay;
    logic               r_chip_en,     n_chip_en;
    t_status            r_status,      n_status;

    logic               shown;
    logic               go_on;
    logic [LIMIT_W-1:0] limit;
    logic [WW-1:0]      number;
    logic [WW+15:0]     number_ext;

    always_comb begin
        n_load_left   = r_load_left;
        n_unload_left = r_unload_left;
        n_cycle_done  = r_cycle_done;
        n_fail_run    = r_fail_run;
        n_test_index  = r_test_index;
        n_pending     = r_pending;
        n_quit        = r_quit;
        n_relay       = r_relay;
        n_chip_en     = r_chip_en;
        n_status      = r_status;
        shown         = 1'b0;
        go_on         = 1'b1;
        limit = (i_cfg.relay_fail_limit == '0) ? LIMIT_W'(1) : i_cfg.relay_fail_limit;

        if (r_status == ST_RUNNING) begin
            if (i_in.quit_pressed) begin
                n_quit = 1'b1;
            end
            if (i_in.tick_elapsed) begin
                // advance the load and unload counters
                if (n_load_left != '0) begin
                    n_load_left = n_load_left - CW'(1);
                    if (n_load_left == '0) begin
                        n_unload_left = WW'(i_cfg.unload_ticks) + WW'(1);
                    end
                end
                if (n_unload_left != '0) begin
                    n_unload_left = n_unload_left - WW'(1);
                    if (n_unload_left == '0) begin
                        n_cycle_done = 1'b1;
                    end
                end

                if (33'(r_test_index) <= 33'(i_cfg.total_tests)) begin
                    if (n_pending) begin
                        n_pending = 1'b0;
                        shown     = 1'b1;
                    end
                    if (n_load_left == '0 && n_unload_left == '0 && !n_cycle_done) begin
                        n_load_left = (i_cfg.load_ticks == '0) ? CW'(1)
                                                               : CW'(i_cfg.load_ticks);
                    end
                    if (n_cycle_done) begin
                        n_cycle_done = 1'b0;
                        // relay check, then supply, then output short, then quit request
                        if (!i_in.relay_sense) begin
                            if (n_fail_run < FAIL_RUN_MAX) begin
                                n_fail_run = n_fail_run + LIMIT_W'(1);
                            end
                            if (n_fail_run >= limit) begin
                                n_status = ST_RELAY_ERR;
                                go_on    = 1'b0;
                            end
                        end else begin
                            n_fail_run = '0;
                        end
                        if (go_on && !i_in.supply_sense) begin
                            n_status = ST_SUPPLY_ERR;
                            go_on    = 1'b0;
                        end
                        if (go_on) begin
                            if (i_in.vout_sense) begin
                                n_chip_en = 1'b0;
                                n_status  = ST_CHIP_ERR;
                                go_on     = 1'b0;
                            end else begin
                                n_chip_en = 1'b1;
                            end
                        end
                        if (go_on && n_quit) begin
                            n_status = ST_QUIT;
                            go_on    = 1'b0;
                        end
                        if (go_on) begin
                            n_test_index = n_test_index + WW'(1);
                            n_pending    = 1'b1;
                        end
                    end
                end else begin
                    n_status = ST_PASSED;
                    go_on    = 1'b0;
                end

                if (go_on) begin
                    if (n_load_left != '0) begin
                        n_relay = 1'b1;
                    end else if (n_unload_left != '0) begin
                        n_relay = 1'b0;
                    end
                end
            end
        end

        number     = (n_status == ST_PASSED) ? n_test_index - WW'(1) : n_test_index;
        number_ext = {16'd0, number};

        o_result.relay_load        = n_relay;
        o_result.chip_enable       = n_chip_en;
        o_result.shown_test_number = number_ext[15:0];
        o_result.show_number       = shown;
        o_result.run_status        = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_left   <= '0;
            r_unload_left <= '0;
            r_cycle_done  <= 1'b0;
            r_fail_run    <= '0;
            r_test_index  <= WW'(1);
            r_pending     <= 1'b1;
            r_quit        <= 1'b0;
            r_relay       <= 1'b0;
            r_chip_en     <= 1'b1;
            r_status      <= ST_RUNNING;
        end else if (i_step) begin
            r_load_left   <= n_load_left;
            r_unload_left <= n_unload_left;
            r_cycle_done  <= n_cycle_done;
            r_fail_run    <= n_fail_run;
            r_test_index  <= n_test_index;
            r_pending     <= n_pending;
            r_quit        <= n_quit;
            r_relay       <= n_relay;
            r_chip_en     <= n_chip_en;
            r_status      <= n_status;
        end
    end

endmodule
